// ===== rtl/circle_collision_push_defines.svh =====
// assertion macros for the circle collision push block
// used by rtl files that assert; needs clk and arst_n in scope
`ifndef CIRCLE_COLLISION_PUSH_DEFINES_SVH
`define CIRCLE_COLLISION_PUSH_DEFINES_SVH

// same-cycle implication
`define CCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ccp_pkg.sv =====
// shared types and codes for the circle collision push block
// no dependencies
package ccp_pkg;

	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_CIRCLE,
		MODE_FIXED
	} mode_t;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_RECT   = 2'd2;
	localparam logic [1:0] KIND_SPARE  = 2'd3;

	localparam int RADIUS_RESET = 16384;

endpackage

// ===== rtl/ccp_sqrt_cell.sv =====
// one cell of the pipelined integer square root, one root bit per cell
// no package dependencies
module ccp_sqrt_cell #(
	parameter int MW = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_i,
	input  logic [2*MW-1:0]   rad_i,
	input  logic [MW+1:0]     rem_i,
	input  logic [MW-1:0]     root_i,
	output logic              v_o,
	output logic [2*MW-1:0]   rad_o,
	output logic [MW+1:0]     rem_o,
	output logic [MW-1:0]     root_o
);

	logic [MW+3:0] rem_sh;
	logic [MW+3:0] trial;
	logic          take;

	logic            v_q;
	logic [2*MW-1:0] rad_q;
	logic [MW+1:0]   rem_q;
	logic [MW-1:0]   root_q;

	always_comb begin
		rem_sh = {rem_i, rad_i[2*MW-1 -: 2]};
		trial  = {2'b00, root_i, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_i[2*MW-3:0], 2'b00};
		rem_q  <= take ? (MW+2)'(rem_sh - trial) : (MW+2)'(rem_sh);
		root_q <= {root_i[MW-2:0], take};
	end

	assign v_o    = v_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule

// ===== rtl/ccp_div_cell.sv =====
// one cell of the pipelined restoring divider, one quotient bit per cell, two lanes
// no package dependencies
module ccp_div_cell #(
	parameter int MW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_i,
	input  logic [MW-1:0] den_i,
	input  logic [MW-1:0] rem_x_i,
	input  logic [MW-1:0] rem_y_i,
	input  logic [MW-1:0] num_x_i,
	input  logic [MW-1:0] num_y_i,
	input  logic [MW-1:0] quo_x_i,
	input  logic [MW-1:0] quo_y_i,
	output logic          v_o,
	output logic [MW-1:0] den_o,
	output logic [MW-1:0] rem_x_o,
	output logic [MW-1:0] rem_y_o,
	output logic [MW-1:0] num_x_o,
	output logic [MW-1:0] num_y_o,
	output logic [MW-1:0] quo_x_o,
	output logic [MW-1:0] quo_y_o
);

	logic [MW:0] rs_x;
	logic [MW:0] rs_y;
	logic [MW:0] den_e;
	logic        tk_x;
	logic        tk_y;

	logic          v_q;
	logic [MW-1:0] den_q;
	logic [MW-1:0] rem_x_q;
	logic [MW-1:0] rem_y_q;
	logic [MW-1:0] num_x_q;
	logic [MW-1:0] num_y_q;
	logic [MW-1:0] quo_x_q;
	logic [MW-1:0] quo_y_q;

	always_comb begin
		rs_x  = {rem_x_i, num_x_i[MW-1]};
		rs_y  = {rem_y_i, num_y_i[MW-1]};
		den_e = {1'b0, den_i};
		tk_x  = (rs_x >= den_e);
		tk_y  = (rs_y >= den_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		den_q   <= den_i;
		rem_x_q <= tk_x ? MW'(rs_x - den_e) : MW'(rs_x);
		rem_y_q <= tk_y ? MW'(rs_y - den_e) : MW'(rs_y);
		num_x_q <= {num_x_i[MW-2:0], 1'b0};
		num_y_q <= {num_y_i[MW-2:0], 1'b0};
		quo_x_q <= {quo_x_i[MW-2:0], tk_x};
		quo_y_q <= {quo_y_i[MW-2:0], tk_y};
	end

	assign v_o     = v_q;
	assign den_o   = den_q;
	assign rem_x_o = rem_x_q;
	assign rem_y_o = rem_y_q;
	assign num_x_o = num_x_q;
	assign num_y_o = num_y_q;
	assign quo_x_o = quo_x_q;
	assign quo_y_o = quo_y_q;

endmodule

// ===== rtl/circle_collision_push.sv =====
// top level of the circle collision push block
// uses ccp_pkg, ccp_sqrt_cell, ccp_div_cell and circle_collision_push_defines.svh
// Takes one item per clock (busy is always low) and gives its result on
// push_x/push_y with done high for one cycle. An item passes through the
// square root chain (COORD_BITS+1 cells) and the divider chain
// (COORD_BITS+1 cells), plus five single stages. The receiver cannot stall
// the block. player_radius may be written only while no item is
// in flight; cfg_ready is always high.
`include "circle_collision_push_defines.svh"

module circle_collision_push #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] offset_x,
	input  logic signed [COORD_BITS-1:0] offset_y,
	input  logic [1:0]                   other_kind,
	input  logic [COORD_BITS-1:0]        other_radius,
	input  logic [COORD_BITS-1:0]        rect_width,
	input  logic [COORD_BITS-1:0]        rect_height,
	output logic                         done,
	output logic signed [COORD_BITS-1:0] push_x,
	output logic signed [COORD_BITS-1:0] push_y,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [COORD_BITS-1:0]        player_radius
);

	localparam int W    = COORD_BITS;
	localparam int MW   = W + 1;
	localparam int SW   = 2 * MW;
	localparam int SATW = W + 3;

	typedef struct packed {
		ccp_pkg::mode_t      mode;
		logic                kill;
		logic                neg_x;
		logic                neg_y;
		logic [MW-1:0]       ax;
		logic [MW-1:0]       ay;
		logic [MW-1:0]       rsum;
		logic signed [W-1:0] bx;
		logic signed [W-1:0] by;
	} sb_t;

	function automatic logic signed [W-1:0] sat_w(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] hi;
		logic signed [SATW-1:0] lo;
		hi = {4'b0000, {(W-1){1'b1}}};
		lo = {4'b1111, {(W-1){1'b0}}};
		if (v > hi) begin
			return hi[W-1:0];
		end else if (v < lo) begin
			return lo[W-1:0];
		end
		return v[W-1:0];
	endfunction

	logic [W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= W'(ccp_pkg::RADIUS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= player_radius;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// decode
	logic signed [W:0]      dxe, dye, hwe, hhe;
	logic [W-2:0]           hw, hh;
	logic [W-1:0]           mdx, mdy;
	logic signed [SATW-1:0] ovb_x, ovb_y;
	logic signed [MW-1:0]   ex, ey;
	sb_t                    sb_d;

	always_comb begin
		hw  = rect_width[W-1:1];
		hh  = rect_height[W-1:1];
		dxe = {offset_x[W-1], offset_x};
		dye = {offset_y[W-1], offset_y};
		hwe = $signed({2'b00, hw});
		hhe = $signed({2'b00, hh});
		mdx = offset_x[W-1] ? W'(-dxe) : W'(dxe);
		mdy = offset_y[W-1] ? W'(-dye) : W'(dye);
		ovb_x = $signed({3'b000, mdx}) - $signed({4'b0000, hw}) - $signed({3'b000, radius_q});
		ovb_y = $signed({3'b000, mdy}) - $signed({4'b0000, hh}) - $signed({3'b000, radius_q});
		ex = dxe;
		ey = dye;
		sb_d       = '0;
		sb_d.mode  = ccp_pkg::MODE_ZERO;
		sb_d.rsum  = MW'(radius_q) + MW'(other_radius);
		unique case (other_kind)
			ccp_pkg::KIND_CIRCLE: begin
				sb_d.mode = ccp_pkg::MODE_CIRCLE;
			end
			ccp_pkg::KIND_RECT: begin
				if (dxe > -hwe && dxe < hwe) begin
					sb_d.mode = ccp_pkg::MODE_FIXED;
					if (ovb_y < 0) begin
						sb_d.by = sat_w(offset_y > 0 ? ovb_y : -ovb_y);
					end
				end else if (dye > -hhe && dye < hhe) begin
					sb_d.mode = ccp_pkg::MODE_FIXED;
					if (ovb_x < 0) begin
						sb_d.bx = sat_w(offset_x < 0 ? -ovb_x : ovb_x);
					end
				end else begin
					sb_d.mode = ccp_pkg::MODE_CIRCLE;
					sb_d.rsum = MW'(radius_q);
					ex = offset_x < 0 ? dxe + hwe : dxe - hwe;
					ey = offset_y > 0 ? dye - hhe : dye + hhe;
				end
			end
			default: begin
				sb_d.mode = ccp_pkg::MODE_ZERO;
			end
		endcase
		sb_d.neg_x = ex[MW-1];
		sb_d.neg_y = ey[MW-1];
		sb_d.ax    = ex[MW-1] ? MW'(-ex) : MW'(ex);
		sb_d.ay    = ey[MW-1] ? MW'(-ey) : MW'(ey);
	end

	logic v_s1_q, v_s2_q, v_s4_q, v_s5_q, done_q;
	sb_t  sb_s1, sb_s2, sb_s4, sb_s5;
	logic [SW-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk) begin
		sb_s1  <= sb_d;
		sb_s2  <= sb_s1;
		sqx_s2 <= sb_s1.ax * sb_s1.ax;
		sqy_s2 <= sb_s1.ay * sb_s1.ay;
	end

	// square root chain
	logic            sq_v    [MW+1];
	logic [SW-1:0]   sq_rad  [MW+1];
	logic [MW+1:0]   sq_rem  [MW+1];
	logic [MW-1:0]   sq_root [MW+1];
	sb_t             sb_sq   [MW];

	assign sq_v[0]    = v_s2_q;
	assign sq_rad[0]  = sqx_s2 + sqy_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < MW; k++) begin : g_sq
		ccp_sqrt_cell #(.MW(MW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_i    (sq_v[k]),
			.rad_i  (sq_rad[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.v_o    (sq_v[k+1]),
			.rad_o  (sq_rad[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sb_sq[0] <= sb_s2;
		for (int k = 1; k < MW; k++) begin
			sb_sq[k] <= sb_sq[k-1];
		end
	end

	// overlap and scale
	logic [MW-1:0] ov_s4, len_s4, len_s5;
	logic [SW-1:0] prx_s5, pry_s5;
	sb_t           sb_root;

	always_comb begin
		sb_root      = sb_sq[MW-1];
		sb_root.kill = (sq_root[MW] == '0) || (sq_root[MW] >= sb_sq[MW-1].rsum);
	end

	always_ff @(posedge clk) begin
		sb_s4      <= sb_root;
		ov_s4      <= sb_sq[MW-1].rsum - sq_root[MW];
		len_s4     <= sq_root[MW];
		sb_s5      <= sb_s4;
		len_s5     <= len_s4;
		prx_s5     <= sb_s4.ax * ov_s4;
		pry_s5     <= sb_s4.ay * ov_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s4_q <= 1'b0;
			v_s5_q <= 1'b0;
		end else begin
			v_s1_q <= start && !busy;
			v_s2_q <= v_s1_q;
			v_s4_q <= sq_v[MW];
			v_s5_q <= v_s4_q;
		end
	end

	// divider chain
	logic          dv_v    [MW+1];
	logic [MW-1:0] dv_den  [MW+1];
	logic [MW-1:0] dv_remx [MW+1];
	logic [MW-1:0] dv_remy [MW+1];
	logic [MW-1:0] dv_numx [MW+1];
	logic [MW-1:0] dv_numy [MW+1];
	logic [MW-1:0] dv_quox [MW+1];
	logic [MW-1:0] dv_quoy [MW+1];
	sb_t           sb_dv   [MW];

	assign dv_v[0]    = v_s5_q;
	assign dv_den[0]  = len_s5;
	assign dv_remx[0] = prx_s5[SW-1:MW];
	assign dv_remy[0] = pry_s5[SW-1:MW];
	assign dv_numx[0] = prx_s5[MW-1:0];
	assign dv_numy[0] = pry_s5[MW-1:0];
	assign dv_quox[0] = '0;
	assign dv_quoy[0] = '0;

	for (genvar k = 0; k < MW; k++) begin : g_dv
		ccp_div_cell #(.MW(MW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.v_i     (dv_v[k]),
			.den_i   (dv_den[k]),
			.rem_x_i (dv_remx[k]),
			.rem_y_i (dv_remy[k]),
			.num_x_i (dv_numx[k]),
			.num_y_i (dv_numy[k]),
			.quo_x_i (dv_quox[k]),
			.quo_y_i (dv_quoy[k]),
			.v_o     (dv_v[k+1]),
			.den_o   (dv_den[k+1]),
			.rem_x_o (dv_remx[k+1]),
			.rem_y_o (dv_remy[k+1]),
			.num_x_o (dv_numx[k+1]),
			.num_y_o (dv_numy[k+1]),
			.quo_x_o (dv_quox[k+1]),
			.quo_y_o (dv_quoy[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sb_dv[0] <= sb_s5;
		for (int k = 1; k < MW; k++) begin
			sb_dv[k] <= sb_dv[k-1];
		end
	end

	// result
	sb_t                    sb_o;
	logic signed [SATW-1:0] qx, qy;
	logic signed [W-1:0]    rx, ry;
	logic signed [W-1:0]    push_x_q, push_y_q;

	always_comb begin
		sb_o = sb_dv[MW-1];
		qx   = $signed({2'b00, dv_quox[MW]});
		qy   = $signed({2'b00, dv_quoy[MW]});
		rx   = '0;
		ry   = '0;
		unique case (sb_o.mode)
			ccp_pkg::MODE_FIXED: begin
				rx = sb_o.bx;
				ry = sb_o.by;
			end
			ccp_pkg::MODE_CIRCLE: begin
				if (!sb_o.kill) begin
					rx = sat_w(sb_o.neg_x ? qx : -qx);
					ry = sat_w(sb_o.neg_y ? qy : -qy);
				end
			end
			default: begin
				rx = '0;
				ry = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v[MW];
		end
	end

	always_ff @(posedge clk) begin
		push_x_q <= rx;
		push_y_q <= ry;
	end

	assign done   = done_q;
	assign push_x = push_x_q;
	assign push_y = push_y_q;

	`CCP_ASSERT_NEXT(a_item_enters, start && !busy, v_s1_q, "accepted item did not enter pipe")
	`CCP_ASSERT_NEXT(a_result_out, dv_v[MW], done, "divider output not shown as result")
	`CCP_ASSERT_NOW(a_sqrt_rem, sq_v[MW],
		sq_rem[MW] <= {1'b0, sq_root[MW], 1'b0}, "sqrt remainder too large")
	`CCP_ASSERT_NOW(a_div_rem,
		dv_v[MW] && sb_o.mode == ccp_pkg::MODE_CIRCLE && !sb_o.kill,
		dv_remx[MW] < dv_den[MW] && dv_remy[MW] < dv_den[MW],
		"divider remainder not below divisor")
	`CCP_ASSERT_NEXT(a_zero_push, dv_v[MW] && sb_o.mode == ccp_pkg::MODE_ZERO,
		push_x == 0 && push_y == 0, "no collider gave nonzero push")

endmodule

// ===== verif/circle_collision_push_checker.sv =====
// checker for circle_collision_push: predicts each push from the accepted item and compares
// depends on ccp_pkg for kind codes and the reset radius
module circle_collision_push_checker #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic signed [COORD_BITS-1:0] offset_x,
	input  logic signed [COORD_BITS-1:0] offset_y,
	input  logic [1:0]                   other_kind,
	input  logic [COORD_BITS-1:0]        other_radius,
	input  logic [COORD_BITS-1:0]        rect_width,
	input  logic [COORD_BITS-1:0]        rect_height,
	input  logic                         done,
	input  logic signed [COORD_BITS-1:0] push_x,
	input  logic signed [COORD_BITS-1:0] push_y,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [COORD_BITS-1:0]        player_radius,
	output int                           fail_count,
	output int                           pending,
	output int                           push_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} push_t;

	push_t expected_pushes[$];
	logic [COORD_BITS-1:0] radius_q;

	function automatic longint clamp(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic logic [127:0] root_of(logic [127:0] v);
		logic [127:0] rem, root, trial;
		rem = 0;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
			root = root << 1;
			trial = (root << 1) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 128'd1;
			end
		end
		return root;
	endfunction

	function automatic void circle_resolve(input longint ex, input longint ey, input longint ra,
			input longint rb, output longint px, output longint py);
		logic [127:0] ax, ay, len, sum, gap, qx, qy;
		ax = ex < 0 ? -ex : ex;
		ay = ey < 0 ? -ey : ey;
		len = root_of(ax * ax + ay * ay);
		sum = ra + rb;
		px = 0;
		py = 0;
		if (len != 0 && len < sum) begin
			gap = sum - len;
			qx = ax * gap / len;
			qy = ay * gap / len;
			px = clamp(ex < 0 ? longint'(qx) : -longint'(qx));
			py = clamp(ey < 0 ? longint'(qy) : -longint'(qy));
		end
	endfunction

	function automatic push_t predict_push();
		longint dx, dy, hw, hh, r, px, py, ov;
		push_t p;
		dx = offset_x;
		dy = offset_y;
		hw = rect_width >> 1;
		hh = rect_height >> 1;
		r = radius_q;
		px = 0;
		py = 0;
		if (other_kind == ccp_pkg::KIND_CIRCLE) begin
			circle_resolve(dx, dy, r, longint'(other_radius), px, py);
		end else if (other_kind == ccp_pkg::KIND_RECT) begin
			if (dx > -hw && dx < hw) begin
				ov = (dy < 0 ? -dy : dy) - hh - r;
				if (ov < 0)
					py = clamp(dy > 0 ? ov : -ov);
			end else if (dy > -hh && dy < hh) begin
				ov = (dx < 0 ? -dx : dx) - hw - r;
				if (ov < 0)
					px = clamp(dx < 0 ? -ov : ov);
			end else begin
				circle_resolve(dx + (dx < 0 ? hw : -hw), dy + (dy > 0 ? -hh : hh), 0, r,
					px, py);
			end
		end
		p.x = px[COORD_BITS-1:0];
		p.y = py[COORD_BITS-1:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		push_t exp_push;
		int errs;
		errs = 0;
		if (!arst_n) begin
			radius_q <= COORD_BITS'(ccp_pkg::RADIUS_RESET);
			fail_count <= 0;
			push_count <= 0;
			expected_pushes.delete();
		end else begin
			if (done) begin
				push_count <= push_count + 1;
				if (expected_pushes.size() == 0) begin
					$error("push with no item waiting: x %0d y %0d", push_x, push_y);
					errs++;
				end else begin
					exp_push = expected_pushes.pop_front();
					if (push_x !== exp_push.x) begin
						$error("push_x expected %0d actual %0d", exp_push.x, push_x);
						errs++;
					end
					if (push_y !== exp_push.y) begin
						$error("push_y expected %0d actual %0d", exp_push.y, push_y);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (start && !busy)
				expected_pushes.push_back(predict_push());
			if (cfg_valid && cfg_ready)
				radius_q <= player_radius;
		end
	end

	assign pending = expected_pushes.size();
endmodule

// ===== verif/circle_collision_push_tb.sv =====
// testbench top for circle_collision_push: directed and random items, radius changes
// depends on ccp_pkg, the block and circle_collision_push_checker
module circle_collision_push_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 24;
	localparam int DRAIN = 2 * CB + 20;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [CB-1:0] offset_x;
	logic signed [CB-1:0] offset_y;
	logic [1:0]           other_kind;
	logic [CB-1:0]        other_radius;
	logic [CB-1:0]        rect_width;
	logic [CB-1:0]        rect_height;
	logic                 done;
	logic signed [CB-1:0] push_x;
	logic signed [CB-1:0] push_y;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CB-1:0]        player_radius;
	int                   fail_count;
	int                   pending;
	int                   push_count;
	int                   item_count;
	int                   gap_pct;

	circle_collision_push #(.COORD_BITS(CB)) i_dut (.*);

	circle_collision_push_checker #(.COORD_BITS(CB)) i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	task automatic send_item(input logic signed [CB-1:0] ox, input logic signed [CB-1:0] oy,
			input logic [1:0] kind, input logic [CB-1:0] orad,
			input logic [CB-1:0] rw, input logic [CB-1:0] rh);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		offset_x <= ox;
		offset_y <= oy;
		other_kind <= kind;
		other_radius <= orad;
		rect_width <= rw;
		rect_height <= rh;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		item_count++;
	endtask

	task automatic write_radius(input logic [CB-1:0] r);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		player_radius <= r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CB-1:0] rand_size();
		case ($urandom_range(3))
			0: return CB'($urandom_range(0, 16));
			1: return CB'($urandom_range(0, 'h4000));
			2: return CB'($urandom_range(0, 'h40000));
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic logic signed [CB-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CB'(int'($urandom_range(0, 8)) - 4);
			1: return CB'(int'($urandom_range(0, 'h8000)) - 'sh4000);
			2: return CB'(int'($urandom_range(0, 'h80000)) - 'sh40000);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic random_items(input int n);
		logic [1:0] kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(9) == 0 ? ccp_pkg::KIND_SPARE :
				$urandom_range(9) == 0 ? ccp_pkg::KIND_NONE :
				($urandom_range(1) ? ccp_pkg::KIND_CIRCLE : ccp_pkg::KIND_RECT);
			send_item(rand_coord(), rand_coord(), kind, rand_size(), rand_size(),
				rand_size());
		end
	endtask

	localparam logic signed [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};
	localparam logic [CB-1:0] MAXU = '1;

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		player_radius = '0;
		offset_x = '0;
		offset_y = '0;
		other_kind = '0;
		other_radius = '0;
		rect_width = '0;
		rect_height = '0;
		item_count = 0;
		gap_pct = 27;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: kinds, zero offsets, bands, corners, extremes
		send_item(0, 0, ccp_pkg::KIND_NONE, 100, 100, 100);
		send_item(100, -50, ccp_pkg::KIND_SPARE, MAXU, MAXU, MAXU);
		send_item(0, 0, ccp_pkg::KIND_CIRCLE, 'h800, 0, 0);
		send_item(300, 400, ccp_pkg::KIND_CIRCLE, 'h800, 0, 0);
		send_item(-300, -400, ccp_pkg::KIND_CIRCLE, 'h800, 0, 0);
		send_item(MAXC, MAXC, ccp_pkg::KIND_CIRCLE, MAXU, 0, 0);
		send_item(MINC, MINC, ccp_pkg::KIND_CIRCLE, MAXU, 0, 0);
		send_item(MINC, 1, ccp_pkg::KIND_CIRCLE, MAXU, 0, 0);
		send_item(1, 1, ccp_pkg::KIND_CIRCLE, 0, 0, 0);
		send_item(20000, 0, ccp_pkg::KIND_CIRCLE, 2, 0, 0);
		send_item(0, 0, ccp_pkg::KIND_RECT, 0, 'h1000, 'h1000);
		send_item(100, 0, ccp_pkg::KIND_RECT, 0, 'h1000, 'h1000);
		send_item(0, 100, ccp_pkg::KIND_RECT, 0, 'h100, 'h4000);
		send_item(0, -9000, ccp_pkg::KIND_RECT, 0, 'h1000, 'h1000);
		send_item(-9000, 0, ccp_pkg::KIND_RECT, 0, 'h10, 'h1000);
		send_item(3000, 3000, ccp_pkg::KIND_RECT, 0, 'h1000, 'h1000);
		send_item(-3000, -3000, ccp_pkg::KIND_RECT, 0, 'h1000, 'h1000);
		send_item(2048, 2048, ccp_pkg::KIND_RECT, 0, 'h1000, 'h1000);
		send_item(0, 2048, ccp_pkg::KIND_RECT, 0, 0, 'h1000);
		send_item(MINC, MAXC, ccp_pkg::KIND_RECT, 0, MAXU, MAXU);
		send_item(MAXC, MINC, ccp_pkg::KIND_RECT, 0, MAXU, 0);
		send_item(MINC, MINC, ccp_pkg::KIND_RECT, 0, 0, 0);

		write_radius(0);
		random_items(60);
		write_radius(MAXU);
		random_items(60);
		write_radius(1);
		random_items(60);
		write_radius('h2000);
		gap_pct = 0;
		random_items(100);
		gap_pct = 27;
		random_items(150);
		write_radius(CB'($urandom));
		random_items(100);

		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d items and %0d pushes over six radius settings", item_count,
			push_count);
		$display("kinds none, circle, rectangle and unused; bands, corners, extremes");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ccp_pkg.sv
rtl/ccp_sqrt_cell.sv
rtl/ccp_div_cell.sv
rtl/circle_collision_push.sv
verif/circle_collision_push_checker.sv
verif/circle_collision_push_tb.sv
